>>> rtl/i2cm_pkg.sv
// Shared types and codes for the I2C master byte engine.
package i2cm_pkg;

  localparam int unsigned PhaseW = 5;

  localparam logic [PhaseW-1:0] P_IDLE    = 5'd0;
  localparam logic [PhaseW-1:0] P_ST_A    = 5'd1;
  localparam logic [PhaseW-1:0] P_ST_B    = 5'd2;
  localparam logic [PhaseW-1:0] P_ST_C    = 5'd3;
  localparam logic [PhaseW-1:0] P_ST_D    = 5'd4;
  localparam logic [PhaseW-1:0] P_SP_A    = 5'd5;
  localparam logic [PhaseW-1:0] P_SP_B    = 5'd6;
  localparam logic [PhaseW-1:0] P_SP_C    = 5'd7;
  localparam logic [PhaseW-1:0] P_SP_D    = 5'd8;
  localparam logic [PhaseW-1:0] P_WR_OPEN = 5'd9;
  localparam logic [PhaseW-1:0] P_WR_DATA = 5'd10;
  localparam logic [PhaseW-1:0] P_WR_HI   = 5'd11;
  localparam logic [PhaseW-1:0] P_WR_LO   = 5'd12;
  localparam logic [PhaseW-1:0] P_WA_REL  = 5'd13;
  localparam logic [PhaseW-1:0] P_WA_HI   = 5'd14;
  localparam logic [PhaseW-1:0] P_WA_WAIT = 5'd15;
  localparam logic [PhaseW-1:0] P_RD_REL  = 5'd16;
  localparam logic [PhaseW-1:0] P_RD_LO   = 5'd17;
  localparam logic [PhaseW-1:0] P_RD_HI   = 5'd18;
  localparam logic [PhaseW-1:0] P_RD_END  = 5'd19;
  localparam logic [PhaseW-1:0] P_AK_DRV  = 5'd20;
  localparam logic [PhaseW-1:0] P_AK_HI   = 5'd21;
  localparam logic [PhaseW-1:0] P_AK_LO   = 5'd22;
  localparam logic [PhaseW-1:0] P_AK_REL  = 5'd23;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  localparam logic [15:0] AckTimeoutRst = 16'd500;
  localparam logic [3:0]  BitsPerByte   = 4'd8;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [3:0]        bit_count;
    logic [7:0]        shift_reg;
    logic [15:0]       wait_count;
    logic              scl;
    logic              sda;
    logic              ack_choice;
    logic              fail_flag;
    logic [7:0]        rd_byte;
  } eng_state_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_failed;
  } eng_result_t;

  localparam eng_state_t EngStateRst = '{
    phase:      P_IDLE,
    bit_count:  4'd0,
    shift_reg:  8'd0,
    wait_count: 16'd0,
    scl:        1'b1,
    sda:        1'b1,
    ack_choice: 1'b0,
    fail_flag:  1'b0,
    rd_byte:    8'd0
  };

endpackage

>>> rtl/i2cm_step.sv
// Next-state and result logic for one transfer of the byte engine.
module i2cm_step (
  input  i2cm_pkg::eng_state_t  state_i,
  input  logic [2:0]            operation_i,
  input  logic [7:0]            write_data_i,
  input  logic                  send_ack_i,
  input  logic                  sda_sample_i,
  input  logic [15:0]           ack_timeout_i,
  output i2cm_pkg::eng_state_t  state_o,
  output i2cm_pkg::eng_result_t result_o
);
  import i2cm_pkg::*;

  eng_state_t  nxt;
  logic        done;
  logic [3:0]  bit_inc;
  logic [16:0] wait_inc;

  assign bit_inc  = state_i.bit_count + 4'd1;
  assign wait_inc = {1'b0, state_i.wait_count} + 17'd1;

  always_comb begin
    nxt  = state_i;
    done = 1'b0;
    if (operation_i == OP_TICK) begin
      unique case (state_i.phase)
        P_IDLE: ;
        P_ST_A: begin nxt.sda = 1'b1; nxt.phase = P_ST_B; end
        P_ST_B: begin nxt.scl = 1'b1; nxt.phase = P_ST_C; end
        P_ST_C: begin nxt.sda = 1'b0; nxt.phase = P_ST_D; end
        P_ST_D: begin nxt.scl = 1'b0; nxt.phase = P_IDLE; done = 1'b1; end
        P_SP_A: begin nxt.scl = 1'b0; nxt.phase = P_SP_B; end
        P_SP_B: begin nxt.sda = 1'b0; nxt.phase = P_SP_C; end
        P_SP_C: begin nxt.scl = 1'b1; nxt.phase = P_SP_D; end
        P_SP_D: begin nxt.sda = 1'b1; nxt.phase = P_IDLE; done = 1'b1; end
        P_WR_OPEN: begin nxt.scl = 1'b0; nxt.phase = P_WR_DATA; end
        P_WR_DATA: begin
          nxt.sda       = state_i.shift_reg[7];
          nxt.shift_reg = {state_i.shift_reg[6:0], 1'b0};
          nxt.phase     = P_WR_HI;
        end
        P_WR_HI: begin nxt.scl = 1'b1; nxt.phase = P_WR_LO; end
        P_WR_LO: begin
          nxt.scl       = 1'b0;
          nxt.bit_count = bit_inc;
          nxt.phase     = (bit_inc >= BitsPerByte) ? P_WA_REL : P_WR_DATA;
        end
        P_WA_REL: begin nxt.sda = 1'b1; nxt.phase = P_WA_HI; end
        P_WA_HI: begin
          nxt.scl        = 1'b1;
          nxt.wait_count = 16'd0;
          nxt.phase      = P_WA_WAIT;
        end
        P_WA_WAIT: begin
          if (!sda_sample_i) begin
            nxt.scl   = 1'b0;
            nxt.phase = P_IDLE;
            done      = 1'b1;
          end else if (wait_inc > {1'b0, ack_timeout_i}) begin
            // timed out: hold the pins, run a stop next
            nxt.fail_flag = 1'b1;
            nxt.phase     = P_SP_A;
          end else begin
            nxt.wait_count = wait_inc[15:0];
          end
        end
        P_RD_REL: begin nxt.sda = 1'b1; nxt.phase = P_RD_LO; end
        P_RD_LO:  begin nxt.scl = 1'b0; nxt.phase = P_RD_HI; end
        P_RD_HI: begin
          nxt.scl       = 1'b1;
          nxt.shift_reg = {state_i.shift_reg[6:0], sda_sample_i};
          nxt.bit_count = bit_inc;
          nxt.phase     = (bit_inc >= BitsPerByte) ? P_RD_END : P_RD_LO;
        end
        P_RD_END: begin nxt.scl = 1'b0; nxt.phase = P_AK_DRV; end
        P_AK_DRV: begin nxt.sda = ~state_i.ack_choice; nxt.phase = P_AK_HI; end
        P_AK_HI:  begin nxt.scl = 1'b1; nxt.phase = P_AK_LO; end
        P_AK_LO:  begin nxt.scl = 1'b0; nxt.phase = P_AK_REL; end
        P_AK_REL: begin
          nxt.sda     = 1'b1;
          nxt.rd_byte = state_i.shift_reg;
          nxt.phase   = P_IDLE;
          done        = 1'b1;
        end
        default: nxt.phase = P_IDLE;
      endcase
    end else if (state_i.phase == P_IDLE) begin
      unique case (operation_i)
        OP_START: nxt.phase = P_ST_A;
        OP_STOP:  nxt.phase = P_SP_A;
        OP_WRITE: begin
          nxt.shift_reg = write_data_i;
          nxt.bit_count = 4'd0;
          nxt.fail_flag = 1'b0;
          nxt.phase     = P_WR_OPEN;
        end
        OP_READ: begin
          nxt.shift_reg  = 8'd0;
          nxt.bit_count  = 4'd0;
          nxt.ack_choice = send_ack_i;
          nxt.phase      = P_RD_REL;
        end
        default: ;
      endcase
    end
  end

  assign state_o = nxt;

  always_comb begin
    result_o.scl_level  = nxt.scl;
    result_o.sda_level  = nxt.sda;
    result_o.busy_res   = (nxt.phase != P_IDLE);
    result_o.done_res   = done;
    result_o.read_data  = nxt.rd_byte;
    result_o.ack_failed = nxt.fail_flag;
  end

endmodule

>>> rtl/i2cm_out_stage.sv
// Result register with valid/ready handshake toward the master side.
module i2cm_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  i2cm_pkg::eng_result_t result_i,
  output logic                  can_load_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata
);
  import i2cm_pkg::*;

  logic        valid_q;
  eng_result_t res_q;

  // accept a new result when empty or when the held one leaves this cycle
  assign can_load_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {3'd0, res_q.ack_failed, res_q.read_data, res_q.done_res,
                          res_q.busy_res, res_q.sda_level, res_q.scl_level};

endmodule

>>> rtl/i2c_master_byte_engine_top.sv
// I2C master byte engine: pin sequencer for start, stop, byte write and byte read.
// Each input transfer is either a command (start, stop, write, read; used only while
// idle) or a tick that may move SCL or SDA by one edge or sample SDA, and each input
// transfer yields exactly one result transfer with the pin levels, busy, done, the last
// read byte and the ack-failure flag. The sequencer state updates in the cycle the input
// transfer is taken and the result lands in an output register, so one transfer is taken
// every clock cycle; the input side stalls only while a result waits in that register.
// ack_timeout is the number of high SDA samples allowed while waiting for acknowledge.
module i2c_master_byte_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // ack_timeout
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // [7:0] write_data, [8] send_ack, [9] sda_sample
  input  logic [2:0]  s_axis_tuser,    // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata     // [0] scl_level, [1] sda_level, [2] busy_res,
                                       // [3] done_res, [11:4] read_data, [12] ack_failed
);
  import i2cm_pkg::*;

  eng_state_t  state_q, state_d;
  eng_result_t result;
  logic [15:0] ack_timeout_q;
  logic        can_load;
  logic        take;

  assign s_axis_tready = can_load;
  assign take          = s_axis_tvalid && can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= AckTimeoutRst;
    end else if (cfg_we_i) begin
      ack_timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EngStateRst;
    end else if (take) begin
      state_q <= state_d;
    end
  end

  i2cm_step u_step (
    .state_i       (state_q),
    .operation_i   (s_axis_tuser),
    .write_data_i  (s_axis_tdata[7:0]),
    .send_ack_i    (s_axis_tdata[8]),
    .sda_sample_i  (s_axis_tdata[9]),
    .ack_timeout_i (ack_timeout_q),
    .state_o       (state_d),
    .result_o      (result)
  );

  i2cm_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take),
    .result_i      (result),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
